@@ hdl/bbpa_pkg.sv @@
// Shared types and constants for the buffer/block pool allocator.
// Used by bbpa_stack and buffer_block_pool_allocator_top; depends on nothing.
package bbpa_pkg;

    // Both pools share one depth; every stack and table is sized from it.
    localparam int POOL_DEPTH = 64;
    localparam int NUM_BUFS   = POOL_DEPTH;
    localparam int NUM_BLKS   = POOL_DEPTH;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;

    // Request codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_BUF  = 2'd1;
    localparam logic [1:0] ST_NO_BLK  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLKS_IN_USE = 2'd1;

    // Commands into one free-list stack
    typedef struct packed {
        logic             init;
        logic [CNT_W-1:0] init_count;
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_data;
    } t_stk_ctl;

    // Status out of one free-list stack
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_nxt;
        logic [IDX_W-1:0] tos;
    } t_stk_stat;

endpackage

@@ hdl/bbpa_stack.sv @@
// LIFO free list with the two top entries in registers and the rest in a RAM.
// Depends on bbpa_pkg for widths, depth and the control/status structs.
module bbpa_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbpa_pkg::t_stk_ctl  i_ctl,
    output bbpa_pkg::t_stk_stat o_stat
);
    import bbpa_pkg::*;

    // Entries below the top two; an entry never written holds its own index
    logic [IDX_W-1:0]      r_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] r_vld;
    logic [POOL_DEPTH-1:0] n_vld;

    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_tos, n_tos;
    logic [IDX_W-1:0] r_nos, n_nos;

    // Registered read of the third entry from the top
    logic [IDX_W-1:0] r_rd_mem;
    logic             r_rd_hit, n_rd_hit;
    logic [IDX_W-1:0] r_rd_alt, n_rd_alt;
    logic [IDX_W-1:0] rd_data;

    logic             do_init;
    logic [CNT_W-1:0] init_cnt;
    logic [CNT_W-1:0] sat_cnt;
    logic             do_pop;
    logic             do_push;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic [CNT_W-1:0] rd_addr_full;
    logic [IDX_W-1:0] rd_addr;

    assign rd_data = r_rd_hit ? r_rd_alt : r_rd_mem;

    // Reset loads a full pool, a re-init loads the requested count
    assign do_init  = !i_rst_n || i_ctl.init;
    assign init_cnt = !i_rst_n ? CNT_W'(POOL_DEPTH) : i_ctl.init_count;
    assign sat_cnt  = (init_cnt > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : init_cnt;

    assign do_pop  = i_ctl.pop && (r_count != '0);
    assign do_push = i_ctl.push && (r_count < CNT_W'(POOL_DEPTH));

    // Compute next top registers and spill/refill traffic
    always_comb begin
        n_count = r_count;
        n_tos   = r_tos;
        n_nos   = r_nos;
        wr_en   = 1'b0;
        wr_addr = IDX_W'(r_count - CNT_W'(2));
        wr_data = r_nos;
        if (do_init) begin
            n_count = sat_cnt;
            n_tos   = IDX_W'(sat_cnt - CNT_W'(1));
            n_nos   = IDX_W'(sat_cnt - CNT_W'(2));
        end else if (do_push) begin
            // spill the second entry into the RAM
            n_count = r_count + CNT_W'(1);
            n_tos   = i_ctl.push_data;
            n_nos   = r_tos;
            wr_en   = (r_count >= CNT_W'(2));
        end else if (do_pop) begin
            // refill the second entry from the prefetched read
            n_count = r_count - CNT_W'(1);
            n_tos   = r_nos;
            n_nos   = rd_data;
        end
    end

    // Prefetch the entry that will sit third from the top next cycle
    assign rd_addr_full = n_count - CNT_W'(3);
    assign rd_addr      = rd_addr_full[IDX_W-1:0];

    always_comb begin
        n_rd_hit = 1'b0;
        n_rd_alt = rd_addr;
        if (do_init) begin
            n_rd_hit = 1'b1;
        end else if (wr_en && (wr_addr == rd_addr)) begin
            n_rd_hit = 1'b1;
            n_rd_alt = wr_data;
        end else if (!r_vld[rd_addr]) begin
            n_rd_hit = 1'b1;
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (do_init) begin
            n_vld = '0;
        end else if (wr_en) begin
            n_vld[wr_addr] = 1'b1;
        end
    end

    // Control registers; reset is folded into the init path
    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_tos    <= n_tos;
        r_nos    <= n_nos;
        r_rd_hit <= n_rd_hit;
        r_rd_alt <= n_rd_alt;
        r_vld    <= n_vld;
    end

    // RAM write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en && !do_init) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_mem <= r_mem[rd_addr];
    end

    assign o_stat.count     = r_count;
    assign o_stat.count_nxt = n_count;
    assign o_stat.tos       = r_tos;

endmodule

@@ hdl/buffer_block_pool_allocator_top.sv @@
// Buffer/block pool allocator top level: request decode, buffer link table,
// configuration registers. Depends on bbpa_pkg and bbpa_stack.
//
// Usage:
//   Request channel: an item is taken at a clock edge with i_start high and
//   o_busy low. o_busy stays low, so one item can be issued every cycle.
//   Each item produces one result. The link RAM is read at the accepting
//   edge, together with the input register. Decode and stack update take
//   the next cycle and load the result register at its end. o_done is
//   then high for one cycle, and the result is taken while it is high.
//   Throughput is one item per
//   cycle; the stack top registers and the link RAM read port each see one
//   access per item, and the link read is forwarded from the item ahead.
//   The receiver cannot stall; results must be taken when strobed.
//   Configuration channel: o_cfg_ready is always high. Writing index 0 or 1
//   sets the number of buffers or blocks placed on the free lists and
//   rebuilds both lists and clears all links in that same cycle. Writes to
//   other indexes are ignored. Write only while no item is in flight.
//   Reset (synchronous, active low) loads 64 buffers and 64 blocks onto the
//   lists and clears all links; no clearing pass is needed, the block
//   takes items as soon as reset is released.
module buffer_block_pool_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_action,
    input  logic [bbpa_pkg::IDX_W-1:0]     i_buf_index,
    input  logic                           i_buf_present,
    // result channel
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [bbpa_pkg::IDX_W-1:0]     o_granted_buf,
    output logic [bbpa_pkg::IDX_W-1:0]     o_granted_blk,
    output logic                           o_block_released,
    output logic [bbpa_pkg::CNT_W-1:0]     o_free_buf_count,
    output logic [bbpa_pkg::CNT_W-1:0]     o_free_blk_count,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [6:0]                     i_cfg_data
);
    import bbpa_pkg::*;

    // Configuration
    logic [6:0] r_buffers_in_use;
    logic [6:0] r_blocks_in_use;
    logic       cfg_wr;
    logic       cfg_init;
    logic [6:0] n_buffers_in_use;
    logic [6:0] n_blocks_in_use;

    // Buffer-to-block links; a cleared link means no block attached
    logic [IDX_W-1:0]    r_lnk_mem [NUM_BUFS];
    logic [NUM_BUFS-1:0] r_lnk_vld;
    logic [IDX_W-1:0]    r_lnk_rd;
    logic                lnk_wr;
    logic                lnk_clr;

    // Stage 1: accepted request
    logic             r_s1_vld;
    logic [1:0]       r_s1_action;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_present;
    logic             accept;

    // Free lists
    t_stk_ctl  buf_ctl, blk_ctl;
    t_stk_stat buf_stat, blk_stat;

    // Decode results
    logic [1:0]       status;
    logic [IDX_W-1:0] gbuf;
    logic [IDX_W-1:0] gblk;
    logic             released;

    // Result register
    logic             r_done;
    logic [1:0]       r_status;
    logic [IDX_W-1:0] r_gbuf;
    logic [IDX_W-1:0] r_gblk;
    logic             r_released;
    logic [CNT_W-1:0] r_buf_cnt;
    logic [CNT_W-1:0] r_blk_cnt;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // Register writes; either known index rebuilds both lists
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign cfg_init = cfg_wr &&
                      ((i_cfg_index == CFG_BUFS_IN_USE) || (i_cfg_index == CFG_BLKS_IN_USE));
    assign n_buffers_in_use = (cfg_wr && (i_cfg_index == CFG_BUFS_IN_USE)) ?
                              i_cfg_data : r_buffers_in_use;
    assign n_blocks_in_use  = (cfg_wr && (i_cfg_index == CFG_BLKS_IN_USE)) ?
                              i_cfg_data : r_blocks_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffers_in_use <= 7'(NUM_BUFS);
            r_blocks_in_use  <= 7'(NUM_BLKS);
        end else begin
            r_buffers_in_use <= n_buffers_in_use;
            r_blocks_in_use  <= n_blocks_in_use;
        end
    end

    // Decode the request in stage 1. Freeing a linked buffer always returns
    // its block.
    always_comb begin
        status             = ST_OK;
        gbuf               = '0;
        gblk               = '0;
        released           = 1'b0;
        lnk_wr             = 1'b0;
        lnk_clr            = 1'b0;
        buf_ctl.init       = cfg_init;
        buf_ctl.init_count = CNT_W'(n_buffers_in_use);
        buf_ctl.pop        = 1'b0;
        buf_ctl.push       = 1'b0;
        buf_ctl.push_data  = r_s1_idx;
        blk_ctl.init       = cfg_init;
        blk_ctl.init_count = CNT_W'(n_blocks_in_use);
        blk_ctl.pop        = 1'b0;
        blk_ctl.push       = 1'b0;
        blk_ctl.push_data  = r_lnk_rd;
        if (r_s1_vld) begin
            case (r_s1_action)
                ACT_ALLOC: begin
                    if (buf_stat.count == '0) begin
                        status = ST_NO_BUF;
                    end else begin
                        buf_ctl.pop = 1'b1;
                        gbuf        = buf_stat.tos;
                    end
                end
                ACT_GET: begin
                    // block first; without a buffer the block stays on its list
                    if (blk_stat.count == '0) begin
                        status = ST_NO_BLK;
                    end else if (buf_stat.count == '0) begin
                        status = ST_NO_BUF;
                    end else begin
                        buf_ctl.pop = 1'b1;
                        blk_ctl.pop = 1'b1;
                        gbuf        = buf_stat.tos;
                        gblk        = blk_stat.tos;
                        lnk_wr      = 1'b1;
                    end
                end
                ACT_FREE: begin
                    if (!r_s1_present) begin
                        status = ST_INVALID;
                    end else begin
                        if (r_lnk_vld[r_s1_idx]) begin
                            blk_ctl.push = 1'b1;
                            released     = 1'b1;
                        end
                        buf_ctl.push = 1'b1;
                        lnk_clr      = 1'b1;
                    end
                end
                default: begin
                    status = ST_INVALID;
                end
            endcase
        end
    end

    bbpa_stack u_buf_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (buf_ctl),
        .o_stat  (buf_stat)
    );

    bbpa_stack u_blk_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (blk_ctl),
        .o_stat  (blk_stat)
    );

    // Hold the accepted request for decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        r_s1_action  <= i_action;
        r_s1_idx     <= i_buf_index;
        r_s1_present <= i_buf_present;
    end

    // Link RAM: write on get, read at the incoming index with forwarding
    // from the item being decoded this cycle
    always_ff @(posedge i_clk) begin
        if (lnk_wr) begin
            r_lnk_mem[buf_stat.tos] <= blk_stat.tos;
        end
        if (lnk_wr && (buf_stat.tos == i_buf_index)) begin
            r_lnk_rd <= blk_stat.tos;
        end else begin
            r_lnk_rd <= r_lnk_mem[i_buf_index];
        end
    end

    // Link valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_init) begin
            r_lnk_vld <= '0;
        end else if (lnk_wr) begin
            r_lnk_vld[buf_stat.tos] <= 1'b1;
        end else if (lnk_clr) begin
            r_lnk_vld[r_s1_idx] <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_vld;
        end
        r_status   <= status;
        r_gbuf     <= gbuf;
        r_gblk     <= gblk;
        r_released <= released;
        r_buf_cnt  <= buf_stat.count_nxt;
        r_blk_cnt  <= blk_stat.count_nxt;
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_buf    = r_gbuf;
    assign o_granted_blk    = r_gblk;
    assign o_block_released = r_released;
    assign o_free_buf_count = r_buf_cnt;
    assign o_free_blk_count = r_blk_cnt;

endmodule
